FILE: rtl/block_sharing_profiler_core_defines.svh
// Assertion macros for the sharing profiler
`ifndef BLOCK_SHARING_PROFILER_CORE_DEFINES_SVH
`define BLOCK_SHARING_PROFILER_CORE_DEFINES_SVH

// same-cycle implication
`define BSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bsp_pkg.sv
// Shared types and constants of the sharing profiler
`default_nettype none
package bsp_pkg;
    localparam int ADDR_W       = 64;
    localparam int TID_W        = 3;
    localparam int SHIFT_W      = 4;
    localparam int BUCKET_W     = 4;
    localparam int COUNT_W      = 11;
    localparam int HIST_BUCKETS = 8;
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd6;
    localparam logic [BUCKET_W-1:0] BUCKET_TOTAL = 4'd8;

    typedef enum logic {
        KIND_ACCESS = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_REPORT
    } t_back_state;

    typedef struct packed {
        t_kind              kind;
        logic [TID_W-1:0]   tid;
        logic [ADDR_W-1:0]  block;
    } t_req;

    typedef struct packed {
        logic clearing;
    } t_status;
endpackage
`default_nettype wire

FILE: rtl/bsp_ifs.sv
// Channel interfaces: request, result and configuration
`default_nettype none
interface bsp_req_if import bsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [TID_W-1:0]   thread_id;
    logic [ADDR_W-1:0]  byte_address;
    modport source (output valid, kind, thread_id, byte_address, input ready);
    modport sink   (input valid, kind, thread_id, byte_address, output ready);
endinterface

interface bsp_rsp_if import bsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
    logic                overflow;
    logic                last;
    modport source (output valid, bucket, count, overflow, last, input ready);
    modport sink   (input valid, bucket, count, overflow, last, output ready);
endinterface

interface bsp_cfg_if import bsp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SHIFT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/block_sharing_profiler_core.sv
// Top level of the memory block sharing profiler
//  channel  dir  carries
//  i_req    in   kind, thread_id, byte_address
//  o_rsp    out  bucket, count, overflow, last
//  i_cfg    in   block_shift
// After reset the table valid bits are cleared, one entry a cycle.
// An access steps through queue pop, table read and check/write, with a further
// read and check for each extra probe of the linear-probed hash table.
// A report pops the queue, then loads one result a cycle while o_rsp does not
// stall. A two-entry queue lets requests be taken while the table or the
// result side is busy.
`default_nettype none
`include "block_sharing_profiler_core_defines.svh"
module block_sharing_profiler_core import bsp_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int THREADS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bsp_req_if.sink     i_req,
    bsp_cfg_if.sink     i_cfg,
    bsp_rsp_if.source   o_rsp
);
    logic    q_valid, q_ready;
    t_req    q_data;
    t_status status;

    bsp_front #(.THREADS(THREADS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cfg     (i_cfg),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_data  (q_data)
    );

    bsp_back #(.ENTRIES(ENTRIES), .THREADS(THREADS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .o_rsp     (o_rsp),
        .o_status  (status)
    );

    `BSP_ASSERT_NOW(a_no_result_in_clear, i_clk, i_rst_n, status.clearing, !o_rsp.valid, "result during clear")
    `BSP_ASSERT_NOW(a_last_is_total, i_clk, i_rst_n, o_rsp.valid && o_rsp.last, o_rsp.bucket == BUCKET_TOTAL, "last not on total")
    `BSP_ASSERT_NEXT(a_bucket_seq, i_clk, i_rst_n, o_rsp.valid && o_rsp.ready && !o_rsp.last, o_rsp.valid && (o_rsp.bucket == $past(o_rsp.bucket) + 4'd1), "report sequence broken")
endmodule
`default_nettype wire

FILE: rtl/bsp_front.sv
// Front end: block shift register, request decode, two-entry request queue
`default_nettype none
module bsp_front import bsp_pkg::*; #(
    parameter int THREADS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bsp_req_if.sink     i_req,
    bsp_cfg_if.sink     i_cfg,
    output logic        o_q_valid,
    input  wire logic   i_q_ready,
    output t_req        o_q_data
);
    logic [SHIFT_W-1:0] r_shift;
    t_req               r_buf [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    logic               keep, push, pop;
    t_req               req_in;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_cnt != 2'd2);

    always_comb begin
        req_in.kind  = t_kind'(i_req.kind);
        req_in.tid   = i_req.thread_id;
        req_in.block = i_req.byte_address >> r_shift;
    end

    // accesses from threads outside the profiled set are dropped here
    assign keep = (t_kind'(i_req.kind) == KIND_REPORT) || (int'(i_req.thread_id) < THREADS);
    assign push = i_req.valid && i_req.ready && keep;
    assign pop  = o_q_valid && i_q_ready;

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg.valid) r_shift <= i_cfg.data;
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wp] <= req_in;
    end
endmodule
`default_nettype wire

FILE: rtl/bsp_back.sv
// Back end: hashed block table, histogram counters, report sequencer
`default_nettype none
module bsp_back import bsp_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int THREADS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    output logic        o_q_ready,
    input  wire t_req   i_q_data,
    bsp_rsp_if.source   o_rsp,
    output t_status     o_status
);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int PC_W   = $clog2(THREADS + 1);
    localparam int ENT_W  = 1 + ADDR_W + THREADS;
    localparam int FOLDS  = (ADDR_W + IDX_W - 1) / IDX_W;

    logic [ENT_W-1:0]   mem [ENTRIES];
    logic [ENT_W-1:0]   r_rd;
    t_back_state        r_state, n_state;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_probes, n_probes;
    logic [ADDR_W-1:0]  r_block, n_block;
    logic [THREADS-1:0] r_bit, n_bit;
    logic [CNT_W-1:0]   r_hist [HIST_BUCKETS];
    logic [CNT_W-1:0]   n_hist [HIST_BUCKETS];
    logic [CNT_W-1:0]   r_total, n_total;
    logic               r_ovf, n_ovf;
    logic [BUCKET_W-1:0] r_k, n_k;
    logic               r_out_valid, n_out_valid;
    logic [BUCKET_W-1:0] r_out_bucket, n_out_bucket;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [ENT_W-1:0]   mem_wd;
    logic [IDX_W-1:0]   fold, hash;
    logic               rd_valid;
    logic [ADDR_W-1:0]  rd_block;
    logic [THREADS-1:0] rd_sharers;
    logic [PC_W-1:0]    pop_cnt;
    logic               load_out;

    assign rd_valid   = r_rd[ENT_W-1];
    assign rd_block   = r_rd[ADDR_W+THREADS-1:THREADS];
    assign rd_sharers = r_rd[THREADS-1:0];

    always_comb begin
        fold = '0;
        for (int j = 0; j < FOLDS; j++) begin
            fold = fold ^ IDX_W'(i_q_data.block >> (j * IDX_W));
        end
        hash = ({1'b0, fold} >= (IDX_W+1)'(ENTRIES)) ? fold - IDX_W'(ENTRIES) : fold;
    end

    always_comb begin
        pop_cnt = '0;
        for (int t = 0; t < THREADS; t++) begin
            pop_cnt = pop_cnt + PC_W'(rd_sharers[t]);
        end
    end

    assign load_out = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_probes     = r_probes;
        n_block      = r_block;
        n_bit        = r_bit;
        n_hist       = r_hist;
        n_total      = r_total;
        n_ovf        = r_ovf;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_bucket = r_out_bucket;
        n_out_count  = r_out_count;
        n_out_ovf    = r_out_ovf;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_wa       = r_ptr;
        mem_wd       = '0;
        o_q_ready    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_ptr == IDX_W'(ENTRIES - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    if (i_q_data.kind == KIND_REPORT) begin
                        n_k     = '0;
                        n_state = ST_REPORT;
                    end else begin
                        n_block  = i_q_data.block;
                        n_bit    = THREADS'(1) << i_q_data.tid;
                        n_ptr    = hash;
                        n_probes = '0;
                        n_state  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (rd_valid && rd_block == r_block) begin
                    if ((rd_sharers & r_bit) == '0) begin
                        mem_we = 1'b1;
                        mem_wd = {1'b1, r_block, rd_sharers | r_bit};
                        // move the block from its old sharer bucket to the next one
                        for (int b = 0; b < HIST_BUCKETS; b++) begin
                            n_hist[b] = r_hist[b]
                                - CNT_W'(int'(pop_cnt) == b + 1)
                                + CNT_W'(int'(pop_cnt) == b);
                        end
                    end
                    n_state = ST_IDLE;
                end else if (!rd_valid) begin
                    mem_we    = 1'b1;
                    mem_wd    = {1'b1, r_block, r_bit};
                    n_hist[0] = r_hist[0] + 1'b1;
                    n_total   = r_total + 1'b1;
                    n_state   = ST_IDLE;
                end else if (r_probes == CNT_W'(ENTRIES - 1)) begin
                    n_ovf   = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_probes = r_probes + 1'b1;
                    n_ptr    = (r_ptr == IDX_W'(ENTRIES - 1)) ? '0 : r_ptr + 1'b1;
                    n_state  = ST_READ;
                end
            end
            ST_REPORT: begin
                if (load_out) begin
                    n_out_valid  = 1'b1;
                    n_out_bucket = r_k;
                    n_out_last   = (r_k == BUCKET_TOTAL);
                    n_out_count  = (r_k == BUCKET_TOTAL) ? COUNT_W'(r_total)
                                                         : COUNT_W'(r_hist[r_k[2:0]]);
                    // flag is captured with the count; later accesses may set it
                    n_out_ovf    = r_ovf;
                    n_k          = r_k + 1'b1;
                    if (r_k == BUCKET_TOTAL) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_probes    <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < HIST_BUCKETS; b++) r_hist[b] <= '0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_probes    <= n_probes;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_block      <= n_block;
        r_bit        <= n_bit;
        r_out_bucket <= n_out_bucket;
        r_out_count  <= n_out_count;
        r_out_ovf    <= n_out_ovf;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[r_ptr];
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.bucket   = r_out_bucket;
    assign o_rsp.count    = r_out_count;
    assign o_rsp.overflow = r_out_ovf;
    assign o_rsp.last     = r_out_last;

    assign o_status.clearing = (r_state == ST_CLEAR);
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the block sharing profiler core: scoreboard, stimulus and checks
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import bsp_pkg::*;

    localparam int ENTRIES   = 1024;
    localparam int THREADS   = 8;
    localparam int LIMIT     = 4_000_000;
    localparam int SETTLE    = 2 * ENTRIES + 100;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [BUCKET_W-1:0] bucket;
        logic [COUNT_W-1:0]  count;
        logic                overflow;
        logic                last;
    } t_hist_line;

    class sharing_scoreboard;
        logic [SHIFT_W-1:0] shift;
        logic [THREADS-1:0] sharers[logic [ADDR_W-1:0]];
        int unsigned        hist[HIST_BUCKETS];
        int unsigned        total;
        bit                 ovf_seen;
        t_hist_line         pending[$];
        int                 errors;
        int                 checked;
        int                 accesses;
        int                 reports;

        function new();
            shift = SHIFT_RESET;
            total = 0;
            ovf_seen = 0;
            errors = 0;
            checked = 0;
            accesses = 0;
            reports = 0;
            foreach (hist[i]) hist[i] = 0;
        endfunction

        function void note_request(t_kind k, logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr);
            logic [ADDR_W-1:0]  blk;
            logic [THREADS-1:0] bit_m;
            t_hist_line         line;
            int unsigned        c;
            if (k == KIND_ACCESS) begin
                accesses++;
                if (tid >= THREADS) return;
                blk = addr >> shift;
                bit_m = '0;
                bit_m[tid] = 1'b1;
                if (sharers.exists(blk)) begin
                    if ((sharers[blk] & bit_m) == '0) begin
                        c = $countones(sharers[blk]);
                        if (c >= 1 && c <= HIST_BUCKETS) hist[c-1]--;
                        if (c + 1 <= HIST_BUCKETS) hist[c]++;
                        sharers[blk] |= bit_m;
                    end
                end else if (total >= ENTRIES) begin
                    ovf_seen = 1;
                end else begin
                    sharers[blk] = bit_m;
                    hist[0]++;
                    total++;
                end
            end else begin
                reports++;
                for (int b = 0; b <= HIST_BUCKETS; b++) begin
                    line.bucket   = b[BUCKET_W-1:0];
                    line.count    = (b < HIST_BUCKETS) ? hist[b][COUNT_W-1:0]
                                                       : total[COUNT_W-1:0];
                    line.overflow = ovf_seen;
                    line.last     = (b == HIST_BUCKETS);
                    pending = {pending, line};
                end
            end
        endfunction

        function void check_result(t_hist_line got);
            t_hist_line want;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result bucket=%0d count=%0d ovf=%0b last=%0b",
                         $time, got.bucket, got.count, got.overflow, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.bucket !== want.bucket) begin
                $display("%0t: bucket exp %0d got %0d", $time, want.bucket, got.bucket);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: bucket %0d count exp %0d got %0d",
                         $time, want.bucket, want.count, got.count);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $display("%0t: overflow exp %0b got %0b", $time, want.overflow, got.overflow);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bsp_req_if req ();
    bsp_cfg_if cfg ();
    bsp_rsp_if rsp ();

    block_sharing_profiler_core #(.ENTRIES(ENTRIES), .THREADS(THREADS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .i_cfg   (cfg.sink),
        .o_rsp   (rsp.source)
    );

    sharing_scoreboard sb;
    int  cycles;
    int  hold_left;
    bit  hold_request;
    logic [ADDR_W-1:0] pool[24];

    initial begin
        i_clk = 1'b0;
    end
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: checks, random back-pressure and one long hold-off
    always @(posedge i_clk) begin
        t_hist_line got;
        if (i_rst_n) begin
            if (rsp.valid && rsp.ready) begin
                got.bucket   = rsp.bucket;
                got.count    = rsp.count;
                got.overflow = rsp.overflow;
                got.last     = rsp.last;
                sb.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request <= 1'b0;
                hold_left <= LONG_HOLD;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= (pick_gap() == 0);
            end
        end
    end

    task automatic send(t_kind k, logic [TID_W-1:0] tid, logic [ADDR_W-1:0] addr);
        req.valid        <= 1'b1;
        req.kind         <= k;
        req.thread_id    <= tid;
        req.byte_address <= addr;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(k, tid, addr);
    endtask

    task automatic pause(int n);
        if (n > 0) begin
            req.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // wait for all results, then let any trailing access finish
    task automatic drain_and_settle();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_shift(logic [SHIFT_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.shift = v;
    endtask

    task automatic new_pool();
        foreach (pool[i]) pool[i] = {$urandom, $urandom};
    endtask

    task automatic random_traffic(int n);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] lowmask;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            lowmask = (64'd1 << sb.shift) - 1;
            if (r < 10) begin
                send(KIND_REPORT, TID_W'($urandom), {$urandom, $urandom});
            end else if (r < 20) begin
                send(KIND_ACCESS, TID_W'($urandom), {$urandom, $urandom});
            end else begin
                // shared blocks from a small pool so sharer counts climb
                a = (pool[$urandom_range(0, 23)] & ~lowmask) | ({$urandom, $urandom} & lowmask);
                send(KIND_ACCESS, TID_W'($urandom_range(0, THREADS - 1)), a);
            end
            pause(pick_gap());
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        hold_left = 0;
        hold_request = 0;
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.kind = KIND_ACCESS;
        req.thread_id = '0;
        req.byte_address = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rsp.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty report, address extremes, full sharing of one block
        send(KIND_REPORT, '0, '0);
        send(KIND_ACCESS, 3'd0, 64'd0);
        send(KIND_ACCESS, 3'd7, '1);
        send(KIND_ACCESS, 3'd7, '1);
        for (int t = 0; t < THREADS; t++) send(KIND_ACCESS, t[TID_W-1:0], 64'h1000 + t);
        send(KIND_ACCESS, 3'd2, 64'h1003f);
        send(KIND_ACCESS, 3'd5, 64'h10000);
        send(KIND_ACCESS, 3'd1, 64'h8000_0000_0000_0000);
        send(KIND_REPORT, '1, '1);
        send(KIND_REPORT, '0, '0);
        pause(1);

        new_pool();
        random_traffic(60);
        // long hold on the result side while reports pile up
        hold_request = 1;
        for (int i = 0; i < 6; i++) send(KIND_REPORT, '0, '0);
        random_traffic(60);
        drain_and_settle();

        write_shift(4'd0);
        new_pool();
        random_traffic(110);
        drain_and_settle();

        write_shift(4'd15);
        new_pool();
        random_traffic(70);
        drain_and_settle();

        write_shift(4'd12);
        random_traffic(70);
        drain_and_settle();

        write_shift(4'd3);
        new_pool();
        random_traffic(25);
        send(KIND_REPORT, '0, '0);
        drain_and_settle();

        $display("Covered %0d accesses and %0d reports, %0d results checked.",
                 sb.accesses, sb.reports, sb.checked);
        $display("Shifts 6, 0, 15, 12, 3; %0d blocks tracked, overflow %0b.",
                 sb.total, sb.ovf_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
